/* design/awm_pkg.sv */
`timescale 1ns / 1ps

package awm_pkg;

  localparam logic [15:0] DWELL_MS_RESET    = 16'd300;
  localparam logic [9:0]  OVERHEAD_US_RESET = 10'd50;

  localparam int DIV_STEPS = 32;
  localparam int CNT_W     = $clog2(DIV_STEPS);
  localparam int RATE_W    = 11;
  localparam int ADDR_W    = 3;

  localparam logic REG_DWELL    = 1'b0;
  localparam logic REG_OVERHEAD = 1'b1;

  localparam logic [RATE_W-1:0] RATE_FLOOR = 11'd10;

  typedef struct packed {
    logic load;
    logic step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

  typedef struct packed {
    logic [15:0] dwell_ms;
    logic [9:0]  overhead_us;
  } cfg_t;

  // HT rate in tenths of Mbps, 40 MHz doubling and short guard 10/9 folded in
  function automatic logic [RATE_W-1:0] mcs_rate(input logic [2:0] mcs,
                                                 input logic wide, input logic sg);
    logic [RATE_W-1:0] r;
    r = 11'd65;
    case ({wide, sg})
      2'b00: begin
        case (mcs)
          3'd0: r = 11'd65;   3'd1: r = 11'd130;  3'd2: r = 11'd195;  3'd3: r = 11'd260;
          3'd4: r = 11'd390;  3'd5: r = 11'd520;  3'd6: r = 11'd585;  default: r = 11'd650;
        endcase
      end
      2'b01: begin
        case (mcs)
          3'd0: r = 11'd72;   3'd1: r = 11'd144;  3'd2: r = 11'd216;  3'd3: r = 11'd288;
          3'd4: r = 11'd433;  3'd5: r = 11'd577;  3'd6: r = 11'd650;  default: r = 11'd722;
        endcase
      end
      2'b10: begin
        case (mcs)
          3'd0: r = 11'd130;  3'd1: r = 11'd260;  3'd2: r = 11'd390;  3'd3: r = 11'd520;
          3'd4: r = 11'd780;  3'd5: r = 11'd1040; 3'd6: r = 11'd1170; default: r = 11'd1300;
        endcase
      end
      default: begin
        case (mcs)
          3'd0: r = 11'd144;  3'd1: r = 11'd288;  3'd2: r = 11'd433;  3'd3: r = 11'd577;
          3'd4: r = 11'd866;  3'd5: r = 11'd1155; 3'd6: r = 11'd1300; default: r = 11'd1444;
        endcase
      end
    endcase
    return r;
  endfunction

  function automatic logic [RATE_W-1:0] legacy_rate(input logic [3:0] code);
    logic [RATE_W-1:0] r;
    case (code)
      4'd0, 4'd4:  r = 11'd10;
      4'd1, 4'd5:  r = 11'd20;
      4'd2, 4'd6:  r = 11'd55;
      4'd3, 4'd7:  r = 11'd110;
      4'd8:        r = 11'd480;
      4'd9:        r = 11'd240;
      4'd10:       r = 11'd120;
      4'd11:       r = 11'd60;
      4'd12:       r = 11'd540;
      4'd13:       r = 11'd360;
      4'd14:       r = 11'd180;
      default:     r = 11'd90;
    endcase
    return r;
  endfunction

endpackage

/* design/wifi_airtime_occupancy_meter_top.sv */
`timescale 1ns / 1ps
// Channel   Direction  Handshake           Payload
// in        sink       in_valid/in_stall   mode, ht_format, mcs_index, wide_channel,
//                                          short_guard, legacy_rate, frame_length
// out       source     out_valid/out_stall airtime_us, busy_permille, frames_seen
// apb       slave      psel/penable/pready dwell_ms at 0x0, overhead_us at 0x4
//
// Each request runs one load, 32 steps of the shared restoring divider
// (frame airtime or busy/dwell), then a finish that registers the result.
// A request is taken while the previous result still waits on out_stall.
// Reset is asynchronous, active low; sums, tally and registers reset at once.
// A stalled output holds its result and the finished request waits behind it.

module wifi_airtime_occupancy_meter_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       mode_i,
  input  logic                       ht_format_i,
  input  logic [2:0]                 mcs_index_i,
  input  logic                       wide_channel_i,
  input  logic                       short_guard_i,
  input  logic [3:0]                 legacy_rate_i,
  input  logic [11:0]                frame_length_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [15:0]                airtime_us_o,
  output logic [31:0]                busy_permille_o,
  output logic [31:0]                frames_seen_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [awm_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  awm_pkg::cfg_t    cfg_q;
  awm_pkg::cmd_t    cmd;
  awm_pkg::status_t status;
  logic             reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];

  always_comb begin
    unique case (reg_sel)
      awm_pkg::REG_DWELL:    prdata = {16'b0, cfg_q.dwell_ms};
      awm_pkg::REG_OVERHEAD: prdata = {22'b0, cfg_q.overhead_us};
      default:               prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dwell_ms    <= awm_pkg::DWELL_MS_RESET;
      cfg_q.overhead_us <= awm_pkg::OVERHEAD_US_RESET;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_sel)
        awm_pkg::REG_DWELL:    cfg_q.dwell_ms    <= pwdata[15:0];
        awm_pkg::REG_OVERHEAD: cfg_q.overhead_us <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  awm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  awm_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .cfg_i           (cfg_q),
    .mode_i          (mode_i),
    .ht_format_i     (ht_format_i),
    .mcs_index_i     (mcs_index_i),
    .wide_channel_i  (wide_channel_i),
    .short_guard_i   (short_guard_i),
    .legacy_rate_i   (legacy_rate_i),
    .frame_length_i  (frame_length_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .airtime_us_o    (airtime_us_o),
    .busy_permille_o (busy_permille_o),
    .frames_seen_o   (frames_seen_o)
  );

endmodule

/* design/awm_ctrl.sv */
`timescale 1ns / 1ps

module awm_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  awm_pkg::status_t status_i,
  output awm_pkg::cmd_t    cmd_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_HOLD = 2'd2;

  logic [1:0]               state_q, state_d;
  logic [awm_pkg::CNT_W-1:0] cnt_q, cnt_d;

  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          state_d    = ST_RUN;
        end
      end
      ST_RUN: begin
        cmd_o.step = 1'b1;
        cnt_d      = cnt_q + 1'b1;
        if (cnt_q == awm_pkg::CNT_W'(awm_pkg::DIV_STEPS - 1)) begin
          state_d = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (status_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

/* design/awm_datapath.sv */
`timescale 1ns / 1ps

module awm_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  awm_pkg::cmd_t     cmd_i,
  output awm_pkg::status_t  status_o,
  input  awm_pkg::cfg_t     cfg_i,
  input  logic              mode_i,
  input  logic              ht_format_i,
  input  logic [2:0]        mcs_index_i,
  input  logic              wide_channel_i,
  input  logic              short_guard_i,
  input  logic [3:0]        legacy_rate_i,
  input  logic [11:0]       frame_length_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [15:0]       airtime_us_o,
  output logic [31:0]       busy_permille_o,
  output logic [31:0]       frames_seen_o
);

  logic        mode_q;
  logic [15:0] rem_q;
  logic [31:0] quo_q;
  logic [15:0] div_q;
  logic [31:0] busy_sum_q, frame_tally_q;
  logic        out_valid_q;
  logic [15:0] airtime_q;
  logic [31:0] permille_q, frames_q;

  logic [awm_pkg::RATE_W-1:0] rate_raw, rate;
  logic [18:0]                bits_x10;
  logic [16:0]                rem_sh;
  logic [15:0]                diff;
  logic                       ge;
  logic [15:0]                air;

  always_comb begin
    rate_raw = ht_format_i ? awm_pkg::mcs_rate(mcs_index_i, wide_channel_i, short_guard_i)
                           : awm_pkg::legacy_rate(legacy_rate_i);
    rate     = (rate_raw == '0) ? awm_pkg::RATE_FLOOR : rate_raw;
    // length * 80 = length * 64 + length * 16
    bits_x10 = ({7'b0, frame_length_i} << 6) + ({7'b0, frame_length_i} << 4);
    rem_sh   = {rem_q, quo_q[31]};
    ge       = (rem_sh >= {1'b0, div_q});
    diff     = rem_sh[15:0] - div_q;
    air      = quo_q[15:0] + {6'b0, cfg_i.overhead_us};
  end

  assign status_o.out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q <= mode_i;
      rem_q  <= '0;
      if (mode_i) begin
        quo_q <= busy_sum_q;
        div_q <= (cfg_i.dwell_ms == '0) ? 16'd1 : cfg_i.dwell_ms;
      end else begin
        quo_q <= {13'b0, bits_x10};
        div_q <= {5'b0, rate};
      end
    end else if (cmd_i.step) begin
      rem_q <= ge ? diff : rem_sh[15:0];
      quo_q <= {quo_q[30:0], ge};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      if (mode_q) begin
        airtime_q  <= '0;
        permille_q <= quo_q;
        frames_q   <= frame_tally_q;
      end else begin
        airtime_q  <= air;
        permille_q <= '0;
        frames_q   <= '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_sum_q    <= '0;
      frame_tally_q <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
        if (mode_q) begin
          busy_sum_q    <= '0;
          frame_tally_q <= '0;
        end else begin
          busy_sum_q    <= busy_sum_q + {16'b0, air};
          frame_tally_q <= frame_tally_q + 32'd1;
        end
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign airtime_us_o    = airtime_q;
  assign busy_permille_o = permille_q;
  assign frames_seen_o   = frames_q;

endmodule

/* design/awm_checker.sv */
`timescale 1ns / 1ps

module awm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [15:0] airtime_us_o,
  input logic [31:0] busy_permille_o,
  input logic [31:0] frames_seen_o
);

  // an accepted request keeps the input side busy while it divides
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after accepted request");

  // a new result only comes out of a request in flight
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared with no request in flight");

  // frame results carry no dwell report
  a_frame_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && airtime_us_o != 16'd0) |-> (busy_permille_o == 32'd0 &&
                                                 frames_seen_o == 32'd0))
    else $error("frame result carries dwell fields");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(airtime_us_o) &&
                                      $stable(busy_permille_o) && $stable(frames_seen_o)))
    else $error("stalled result changed");

endmodule

bind wifi_airtime_occupancy_meter_top awm_checker u_awm_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .airtime_us_o    (airtime_us_o),
  .busy_permille_o (busy_permille_o),
  .frames_seen_o   (frames_seen_o)
);
